/* design/quaternion_gyro_aim_stick_mapper_core_defines.svh */
// assertion macros for the gyro aim stick mapper core
// expects signals named clock and reset in the including module
`ifndef QUATERNION_GYRO_AIM_STICK_MAPPER_CORE_DEFINES_SVH
`define QUATERNION_GYRO_AIM_STICK_MAPPER_CORE_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define QGASM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// cause in one cycle implies effect in the next
`define QGASM_ASSERT_NEXT(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) else $error(msg);

`endif

/* design/qgasm_pkg.sv */
// types, constants and the arctangent table of the gyro aim stick mapper
// no dependencies
package qgasm_pkg;

   localparam int CW      = 40;
   localparam int AW      = 28;
   localparam int DW      = AW + 1;
   localparam int MAW     = 33;
   localparam int MBW     = 32;
   localparam int PW      = MAW + MBW;
   localparam int RW      = 61;
   localparam int WW      = 31;
   localparam int VW      = 40;
   localparam int STICK_W = 12;
   localparam int CNT_W   = 5;
   localparam int CSR_IW  = 3;
   localparam int CSR_DW  = 12;

   localparam logic signed [AW-1:0] DEG90  = 28'sd5898240;
   localparam logic signed [AW-1:0] DEG180 = 28'sd11796480;
   localparam logic signed [AW-1:0] DEG360 = 28'sd23592960;
   localparam logic signed [DW-1:0] DEG540 = 29'sd35389440;

   localparam logic [63:0]          ONE60    = 64'h1000_0000_0000_0000;
   localparam logic [RW-1:0]        BIT_INIT = {1'b1, 60'd0};
   localparam logic [WW-1:0]        W_ONE    = 31'h4000_0000;
   localparam logic signed [CW-1:0] HALF_Q30 = 40'sd536870912;

   localparam logic signed [VW-1:0] V_LO   = 40'sd65536;
   localparam logic signed [VW-1:0] V_HI   = 40'sd262144000;
   localparam logic [11:0]          AIM_LO = 12'd1;
   localparam logic [11:0]          AIM_HI = 12'd4000;

   localparam logic [CNT_W-1:0] SQ_LAST   = 5'd3;
   localparam logic [CNT_W-1:0] ROOT_LAST = 5'd30;
   localparam logic [CNT_W-1:0] PROD_LAST = 5'd4;
   localparam logic [CNT_W-1:0] MAP_LAST  = 5'd3;

   typedef struct packed {
      logic                      quat_valid;
      logic signed [31:0]        quat_x;
      logic signed [31:0]        quat_y;
      logic signed [31:0]        quat_z;
      logic                      gyro_pressed;
      logic [STICK_W-1:0]        stick_x;
      logic [STICK_W-1:0]        stick_y;
   } req_type;

   typedef struct packed {
      logic [11:0] right_x;
      logic [11:0] right_y;
      logic [11:0] left_x;
      logic [11:0] left_y;
      logic        gyro_active;
   } rsp_type;

   typedef enum logic [CSR_IW-1:0] {
      CSR_MODE     = 3'd0,
      CSR_YAW_DZ   = 3'd1,
      CSR_ROLL_DZ  = 3'd2,
      CSR_YAW_GAIN = 3'd3,
      CSR_ROLL_GAIN = 3'd4,
      CSR_CENTRE   = 3'd5,
      CSR_STICK_DZ = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_DI    = 2'd0,
      MODE_XI    = 2'd1,
      MODE_SW    = 2'd2,
      MODE_RETRO = 2'd3
   } mode_type;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_SQ    = 9'b000000010,
      S_RINIT = 9'b000000100,
      S_ROOT  = 9'b000001000,
      S_PROD  = 9'b000010000,
      S_CROLL = 9'b000100000,
      S_CYAW  = 9'b001000000,
      S_MAP   = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   typedef struct packed {
      logic                 start;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] x;
   } cordic_req_type;

   typedef struct packed {
      logic                 done;
      logic signed [AW-1:0] angle;
   } cordic_rsp_type;

   function automatic logic signed [AW-1:0] atan_deg(input logic [4:0] i);
      logic signed [AW-1:0] v;
      unique case (i)
         5'd0:  v = 28'sd2949120;
         5'd1:  v = 28'sd1740967;
         5'd2:  v = 28'sd919879;
         5'd3:  v = 28'sd466945;
         5'd4:  v = 28'sd234379;
         5'd5:  v = 28'sd117304;
         5'd6:  v = 28'sd58666;
         5'd7:  v = 28'sd29335;
         5'd8:  v = 28'sd14668;
         5'd9:  v = 28'sd7334;
         5'd10: v = 28'sd3667;
         5'd11: v = 28'sd1833;
         5'd12: v = 28'sd917;
         5'd13: v = 28'sd458;
         5'd14: v = 28'sd229;
         5'd15: v = 28'sd115;
         5'd16: v = 28'sd57;
         5'd17: v = 28'sd29;
         5'd18: v = 28'sd14;
         5'd19: v = 28'sd7;
         5'd20: v = 28'sd4;
         5'd21: v = 28'sd2;
         5'd22: v = 28'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* design/qgasm_mul.sv */
// shared signed multiplier with registered product
// depends on qgasm_pkg
module qgasm_mul (
   input  logic                           clock,
   input  logic signed [qgasm_pkg::MAW-1:0] mul_a,
   input  logic signed [qgasm_pkg::MBW-1:0] mul_b,
   output logic signed [qgasm_pkg::PW-1:0]  mul_p_ff
);
   import qgasm_pkg::*;

   logic signed [PW-1:0] mul_p_in;

   assign mul_p_in = PW'(mul_a) * PW'(mul_b);

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_p_in;
   end

endmodule

/* design/qgasm_cordic.sv */
// iterative vectoring cordic atan2 in degrees, one rotation per cycle
// depends on qgasm_pkg for widths, angle constants and the arctangent table
module qgasm_cordic #(
   parameter int STEPS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  qgasm_pkg::cordic_req_type creq,
   output qgasm_pkg::cordic_rsp_type crsp
);
   import qgasm_pkg::*;

   localparam int SW = $clog2(STEPS);
   localparam logic [SW-1:0] LAST = SW'(STEPS - 1);

   logic signed [CW-1:0] x_ff, y_ff, dx, dy;
   logic signed [AW-1:0] z_ff, tab;
   logic [SW-1:0]        step_ff;
   logic [4:0]           idx;
   logic                 busy_ff, done_ff, on_axis;

   assign idx     = 5'(step_ff);
   assign dx      = y_ff >>> idx;
   assign dy      = x_ff >>> idx;
   assign tab     = atan_deg(idx);
   assign on_axis = (creq.y == '0) || (creq.x == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (busy_ff) begin
            step_ff <= SW'(step_ff + 1'b1);
            if (step_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end else if (creq.start) begin
            step_ff <= '0;
            if (on_axis) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         if (!y_ff[CW-1]) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + tab;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - tab;
         end
      end else if (creq.start) begin
         priority if (creq.y == '0) begin
            z_ff <= creq.x[CW-1] ? DEG180 : '0;
         end else if (creq.x == '0) begin
            z_ff <= creq.y[CW-1] ? -DEG90 : DEG90;
         end else if (creq.x[CW-1]) begin
            if (!creq.y[CW-1]) begin
               x_ff <= creq.y;
               y_ff <= -creq.x;
               z_ff <= DEG90;
            end else begin
               x_ff <= -creq.y;
               y_ff <= creq.x;
               z_ff <= -DEG90;
            end
         end else begin
            x_ff <= creq.x;
            y_ff <= creq.y;
            z_ff <= '0;
         end
      end
   end

   assign crsp.done  = done_ff;
   assign crsp.angle = z_ff;

endmodule

/* design/quaternion_gyro_aim_stick_mapper_core.sv */
// gyro aim stick mapper core: quaternion to right stick aim, left stick conditioning
// depends on qgasm_pkg, qgasm_mul, qgasm_cordic and the core defines header
//
// requests arrive on req_valid/req_ready with one req_type item, results leave on
// rsp_valid/rsp_ready, one rsp_type item per request. registers are written through
// csr_write_en/csr_index/csr_wdata; the user must write them only while the core is
// idle, and the core itself does not enforce this. unknown indexes are dropped.
// a request's time from acceptance to rsp_valid is set by the one-bit-per-cycle
// square root, the shared multiplier and the two cordic passes, one rotation per
// cycle each; axis-aligned angles finish their pass early. one request is in work at
// a time: req_ready is high only when the sequencer is idle.
// the result sits in an output register; a stalled receiver holds it, the next request
// is still taken and runs, and it waits at the end until the register frees up.
// synchronous reset returns registers to their defaults, the stored quaternion to
// identity, gyro aiming off and held angles and left stick values to zero.
`include "quaternion_gyro_aim_stick_mapper_core_defines.svh"
module quaternion_gyro_aim_stick_mapper_core #(
   parameter int CORDIC_STEPS = 24,
   parameter int ADC_BITS     = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  qgasm_pkg::req_type             req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output qgasm_pkg::rsp_type             rsp_data,
   input  logic                           csr_write_en,
   input  logic [qgasm_pkg::CSR_IW-1:0]   csr_index,
   input  logic [qgasm_pkg::CSR_DW-1:0]   csr_wdata
);
   import qgasm_pkg::*;

   localparam int SNW = ((ADC_BITS > STICK_W) ? ADC_BITS : STICK_W) + 2;
   localparam logic signed [SNW-1:0] FULL = SNW'((1 << ADC_BITS) - 1);
   localparam logic signed [SNW-1:0] MID  = SNW'(1 << (ADC_BITS - 1));

   function automatic logic [11:0] snap(input logic [STICK_W-1:0] raw, input logic invert,
                                        input logic [10:0] dz);
      logic signed [SNW-1:0] r, lo, hi;
      r  = $signed(SNW'(raw)) & FULL;
      lo = MID - $signed(SNW'(dz));
      hi = MID + $signed(SNW'(dz));
      if (invert) begin
         r = FULL - r;
      end
      if ((lo < r) && (r < hi)) begin
         r = MID;
      end
      return r[11:0];
   endfunction

   // configuration
   mode_type    mode_ff;
   logic [7:0]  yaw_dz_ff, roll_dz_ff, yaw_gain_ff, roll_gain_ff;
   logic [11:0] centre_ff;
   logic [10:0] stick_dz_ff;

   // sequencer
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // state
   logic [WW-1:0]        qw_ff;
   logic signed [31:0]   qx_ff, qy_ff, qz_ff;
   logic                 gyro_on_ff;
   logic signed [AW-1:0] held_yaw_ff, held_roll_ff;
   logic [11:0]          lx_held_ff, ly_held_ff;

   // working registers
   logic                 qvalid_ff, newly_ff;
   logic [STICK_W-1:0]   sx_ff, sy_ff;
   logic [63:0]          sqx_ff, sqy_ff, sqz_ff, acc_ff;
   logic signed [PW-1:0] pacc_ff;
   logic                 over_ff;
   logic [RW-1:0]        rem_ff, res_ff, bit_ff, rem_in, res_in;
   logic [RW:0]          root_t;
   logic                 root_ge;
   logic signed [CW-1:0] num_r_ff, den_r_ff, num_y_ff, den_y_ff;
   logic signed [AW-1:0] roll_ff, yaw_ff, ang_neg, yaw_val;
   logic                 ax_ff, inside_ff;
   logic signed [DW-1:0] d_ff, m_ff, lim_s;
   logic [11:0]          rx_ff, ry_ff, aim_val;
   logic signed [VW-1:0] vsum;
   logic [64:0]          sum_xy, sum_yz;

   // output
   logic    rsp_valid_ff, rsp_load, req_accept, use_new;
   rsp_type rsp_ff;
   logic [11:0] snap_x, snap_y;

   // shared units
   logic signed [MAW-1:0] mul_a;
   logic signed [MBW-1:0] mul_b;
   logic signed [PW-1:0]  mul_p;
   cordic_req_type        cord_req;
   cordic_rsp_type        cord_rsp;

   qgasm_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_p_ff (mul_p)
   );

   qgasm_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .creq  (cord_req),
      .crsp  (cord_rsp)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_SQ) begin
         unique case (cnt_ff)
            5'd0:    begin mul_a = MAW'(qx_ff); mul_b = qx_ff; end
            5'd1:    begin mul_a = MAW'(qy_ff); mul_b = qy_ff; end
            default: begin mul_a = MAW'(qz_ff); mul_b = qz_ff; end
         endcase
      end else if (state_ff == S_PROD) begin
         unique case (cnt_ff)
            5'd0:    begin mul_a = $signed(MAW'(qw_ff)); mul_b = qx_ff; end
            5'd1:    begin mul_a = MAW'(qy_ff); mul_b = qz_ff; end
            5'd2:    begin mul_a = MAW'(qx_ff); mul_b = qy_ff; end
            default: begin mul_a = $signed(MAW'(qw_ff)); mul_b = qz_ff; end
         endcase
      end else begin
         mul_a = MAW'(m_ff);
         mul_b = $signed(MBW'(ax_ff ? roll_gain_ff : yaw_gain_ff));
      end
   end

   // square root step
   assign root_t  = {1'b0, res_ff} + {1'b0, bit_ff};
   assign root_ge = {1'b0, rem_ff} >= root_t;
   assign rem_in  = root_ge ? rem_ff - root_t[RW-1:0] : rem_ff;
   assign res_in  = root_ge ? (res_ff >> 1) + bit_ff : res_ff >> 1;

   assign sum_xy = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign sum_yz = {1'b0, sqy_ff} + {1'b0, sqz_ff};

   assign cord_req.start = ((state_ff == S_CROLL) || (state_ff == S_CYAW)) && (cnt_ff == '0);
   assign cord_req.y     = (state_ff == S_CROLL) ? num_r_ff : num_y_ff;
   assign cord_req.x     = (state_ff == S_CROLL) ? den_r_ff : den_y_ff;

   assign ang_neg = -cord_rsp.angle;
   assign yaw_val = ang_neg[AW-1] ? ang_neg + DEG360 : ang_neg;

   assign lim_s = $signed(DW'({(ax_ff ? roll_dz_ff : yaw_dz_ff), 16'd0}));
   assign vsum  = $signed(mul_p[VW-1:0]) + $signed(VW'({centre_ff, 16'd0}));

   always_comb begin
      priority if (inside_ff) begin
         aim_val = centre_ff;
      end else if (vsum < V_LO) begin
         aim_val = AIM_LO;
      end else if (vsum > V_HI) begin
         aim_val = AIM_HI;
      end else begin
         aim_val = vsum[27:16];
      end
   end

   assign snap_x  = snap(sx_ff, 1'b0, stick_dz_ff);
   assign snap_y  = snap(sy_ff, mode_ff == MODE_XI, stick_dz_ff);
   assign use_new = (mode_ff == MODE_XI) || (mode_ff == MODE_SW);

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SQ;
               cnt_in   = '0;
            end
         end
         S_SQ: begin
            if (cnt_ff == SQ_LAST) begin
               state_in = S_RINIT;
               cnt_in   = '0;
            end else begin
               cnt_in = CNT_W'(cnt_ff + 1'b1);
            end
         end
         S_RINIT: begin
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (cnt_ff == ROOT_LAST) begin
               state_in = S_PROD;
               cnt_in   = '0;
            end else begin
               cnt_in = CNT_W'(cnt_ff + 1'b1);
            end
         end
         S_PROD: begin
            if (cnt_ff == PROD_LAST) begin
               state_in = S_CROLL;
               cnt_in   = '0;
            end else begin
               cnt_in = CNT_W'(cnt_ff + 1'b1);
            end
         end
         S_CROLL: begin
            if (cord_rsp.done) begin
               state_in = S_CYAW;
               cnt_in   = '0;
            end else begin
               cnt_in = 5'd1;
            end
         end
         S_CYAW: begin
            if (cord_rsp.done) begin
               state_in = S_MAP;
               cnt_in   = '0;
            end else begin
               cnt_in = 5'd1;
            end
         end
         S_MAP: begin
            if (cnt_ff == MAP_LAST) begin
               cnt_in = '0;
               if (ax_ff) begin
                  state_in = S_DONE;
               end
            end else begin
               cnt_in = CNT_W'(cnt_ff + 1'b1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         mode_ff      <= MODE_XI;
         yaw_dz_ff    <= 8'd2;
         roll_dz_ff   <= 8'd3;
         yaw_gain_ff  <= 8'd24;
         roll_gain_ff <= 8'd27;
         centre_ff    <= 12'd1975;
         stick_dz_ff  <= 11'd260;
         qw_ff        <= W_ONE;
         qx_ff        <= '0;
         qy_ff        <= '0;
         qz_ff        <= '0;
         gyro_on_ff   <= 1'b0;
         held_yaw_ff  <= '0;
         held_roll_ff <= '0;
         lx_held_ff   <= '0;
         ly_held_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_write_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_MODE:      mode_ff      <= mode_type'(csr_wdata[1:0]);
               CSR_YAW_DZ:    yaw_dz_ff    <= csr_wdata[7:0];
               CSR_ROLL_DZ:   roll_dz_ff   <= csr_wdata[7:0];
               CSR_YAW_GAIN:  yaw_gain_ff  <= csr_wdata[7:0];
               CSR_ROLL_GAIN: roll_gain_ff <= csr_wdata[7:0];
               CSR_CENTRE:    centre_ff    <= csr_wdata[11:0];
               CSR_STICK_DZ:  stick_dz_ff  <= csr_wdata[10:0];
               default: ;
            endcase
         end
         if (req_accept) begin
            gyro_on_ff <= req_data.gyro_pressed;
            if (req_data.quat_valid) begin
               qx_ff <= req_data.quat_x;
               qy_ff <= req_data.quat_y;
               qz_ff <= req_data.quat_z;
            end
         end
         if ((state_ff == S_ROOT) && (cnt_ff == ROOT_LAST) && qvalid_ff) begin
            qw_ff <= over_ff ? '0 : WW'(res_in);
         end
         // switching on takes the current angles as the reference
         if ((state_ff == S_CROLL) && cord_rsp.done && newly_ff) begin
            held_roll_ff <= cord_rsp.angle;
         end
         if ((state_ff == S_CYAW) && cord_rsp.done && newly_ff) begin
            held_yaw_ff <= yaw_val;
         end
         if (rsp_load && use_new) begin
            lx_held_ff <= snap_x;
            ly_held_ff <= snap_y;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_accept) begin
         qvalid_ff <= req_data.quat_valid;
         newly_ff  <= req_data.gyro_pressed && !gyro_on_ff;
         sx_ff     <= req_data.stick_x;
         sy_ff     <= req_data.stick_y;
         ax_ff     <= 1'b0;
      end
      if (state_ff == S_SQ) begin
         unique case (cnt_ff)
            5'd1: begin
               sqx_ff <= mul_p[63:0];
               acc_ff <= mul_p[63:0];
            end
            5'd2: begin
               sqy_ff <= mul_p[63:0];
               acc_ff <= acc_ff + mul_p[63:0];
            end
            5'd3: begin
               sqz_ff <= mul_p[63:0];
               acc_ff <= acc_ff + mul_p[63:0];
            end
            default: ;
         endcase
      end
      if (state_ff == S_RINIT) begin
         over_ff <= acc_ff >= ONE60;
         rem_ff  <= RW'(ONE60 - acc_ff);
         res_ff  <= '0;
         bit_ff  <= BIT_INIT;
      end
      if (state_ff == S_ROOT) begin
         rem_ff <= rem_in;
         res_ff <= res_in;
         bit_ff <= bit_ff >> 2;
      end
      if (state_ff == S_PROD) begin
         unique case (cnt_ff)
            5'd0: den_r_ff <= HALF_Q30 - $signed(CW'(sum_xy >> 30));
            5'd1: begin
               den_y_ff <= HALF_Q30 - $signed(CW'(sum_yz >> 30));
               pacc_ff  <= mul_p;
            end
            5'd2: num_r_ff <= CW'((pacc_ff + mul_p) >>> 30);
            5'd3: pacc_ff  <= mul_p;
            5'd4: num_y_ff <= CW'((pacc_ff + mul_p) >>> 30);
            default: ;
         endcase
      end
      if ((state_ff == S_CROLL) && cord_rsp.done) begin
         roll_ff <= cord_rsp.angle;
      end
      if ((state_ff == S_CYAW) && cord_rsp.done) begin
         yaw_ff <= yaw_val;
      end
      if (state_ff == S_MAP) begin
         unique case (cnt_ff)
            5'd0: begin
               if (!gyro_on_ff) begin
                  d_ff <= '0;
               end else if (ax_ff) begin
                  d_ff <= DW'(roll_ff) - DW'(held_roll_ff);
               end else begin
                  d_ff <= DW'(yaw_ff) - DW'(held_yaw_ff);
               end
            end
            5'd1: begin
               inside_ff <= (-lim_s < d_ff) && (d_ff < lim_s);
               // truncating modulo of the offset shifted by half a turn
               priority if (d_ff >= DW'(DEG180)) begin
                  m_ff <= d_ff - DW'(DEG360);
               end else if (d_ff <= -DEG540) begin
                  m_ff <= d_ff + DW'(DEG360);
               end else begin
                  m_ff <= d_ff;
               end
            end
            5'd3: begin
               if (ax_ff) begin
                  ry_ff <= aim_val;
               end else begin
                  rx_ff <= aim_val;
                  ax_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (rsp_load) begin
         rsp_ff.right_x     <= rx_ff;
         rsp_ff.right_y     <= ry_ff;
         rsp_ff.left_x      <= use_new ? snap_x : lx_held_ff;
         rsp_ff.left_y      <= use_new ? snap_y : ly_held_ff;
         rsp_ff.gyro_active <= gyro_on_ff;
      end
   end

   `QGASM_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "request taken while a request is in work")
   `QGASM_ASSERT(a_cordic_done_in_pass, cord_rsp.done |-> (state_ff == S_CROLL || state_ff == S_CYAW), "cordic result outside an angle pass")
   `QGASM_ASSERT_NEXT(a_load_gives_result, rsp_load, rsp_valid && rsp_data.gyro_active == $past(gyro_on_ff), "result register not loaded")

endmodule

/* tb/tb.sv */
// self-checking testbench for quaternion_gyro_aim_stick_mapper_core
// depends on qgasm_pkg and the core rtl; predicts each response in-line and compares on arrival
`timescale 1ns / 1ps
module tb;
   import qgasm_pkg::*;

   localparam logic [CSR_IW-1:0] BAD_INDEX = 3'd7;
   localparam int STEPS = 24;
   localparam longint A90 = 64'sd5898240;
   localparam longint A180 = 64'sd11796480;
   localparam longint A360 = 64'sd23592960;
   localparam longint Q30 = 64'sd1073741824;
   localparam longint ATAN_DEG [32] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic csr_write_en;
   logic [CSR_IW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_wdata;

   quaternion_gyro_aim_stick_mapper_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // mapper state as predicted
   logic [1:0] cfg_mode;
   logic [7:0] cfg_yaw_dz, cfg_roll_dz, cfg_yaw_gain, cfg_roll_gain;
   logic [11:0] cfg_centre;
   logic [10:0] cfg_stick_dz;
   longint q_w, q_x, q_y, q_z, ref_yaw, ref_roll;
   bit aim_on;
   logic [11:0] left_x_hold, left_y_hold;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int fail_count = 0;
   bit req_fire = 0, quiet = 0;
   int req_gap = 0, rsp_gap = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

   function automatic longint unsigned root60(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint atan2_deg(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (y == 0) return (x >= 0) ? 64'sd0 : A180;
      if (x == 0) return (y > 0) ? A90 : -A90;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = A90;
         end else begin
            t = x; x = -y; y = t; z = -A90;
         end
      end
      for (int i = 0; i < STEPS && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx; y = y - dy; z = z + ATAN_DEG[i];
         end else begin
            x = x - dx; y = y + dy; z = z - ATAN_DEG[i];
         end
      end
      return z;
   endfunction

   function automatic longint half_less(longint a, longint b);
      longint unsigned s;
      s = a * a + b * b;
      return (64'sd1 <<< 29) - longint'(s >> 30);
   endfunction

   function automatic void euler(output longint yaw, output longint roll);
      longint a;
      roll = atan2_deg((q_w * q_x + q_y * q_z) >>> 30, half_less(q_x, q_y));
      a = -atan2_deg((q_x * q_y + q_w * q_z) >>> 30, half_less(q_y, q_z));
      if (a < 0) a = a + A360;
      yaw = a;
   endfunction

   function automatic logic [11:0] aim_value(longint d, logic [7:0] dz, logic [7:0] gain);
      longint lim, r, v;
      lim = longint'(dz) * 65536;
      if (-lim < d && d < lim) return cfg_centre;
      r = (d + A180) % A360;
      v = (r - A180) * longint'(gain) + longint'(cfg_centre) * 65536;
      if (v < 65536) return 12'd1;
      if (v > 64'sd262144000) return 12'd4000;
      return v[27:16];
   endfunction

   function automatic logic [11:0] snap_stick(logic [11:0] raw, bit inv);
      int r, dz;
      r = raw;
      dz = cfg_stick_dz;
      if (inv) r = 4095 - r;
      if (2048 - dz < r && r < 2048 + dz) return 12'd2048;
      return r[11:0];
   endfunction

   function automatic rsp_type predict_rsp(req_type q);
      longint x, y, z, yaw, roll;
      longint unsigned s;
      rsp_type o;
      if (q.quat_valid) begin
         x = q.quat_x;
         y = q.quat_y;
         z = q.quat_z;
         s = x * x + y * y + z * z;
         q_w = (s >= (64'd1 << 60)) ? 64'sd0 : longint'(root60((64'd1 << 60) - s));
         q_x = x; q_y = y; q_z = z;
      end
      if (q.gyro_pressed != aim_on) begin
         aim_on = q.gyro_pressed;
         if (aim_on) begin
            euler(yaw, roll);
            ref_yaw = yaw;
            ref_roll = roll;
         end
      end
      if (aim_on) begin
         euler(yaw, roll);
         o.right_x = aim_value(yaw - ref_yaw, cfg_yaw_dz, cfg_yaw_gain);
         o.right_y = aim_value(roll - ref_roll, cfg_roll_dz, cfg_roll_gain);
      end else begin
         o.right_x = aim_value(0, cfg_yaw_dz, cfg_yaw_gain);
         o.right_y = aim_value(0, cfg_roll_dz, cfg_roll_gain);
      end
      if (cfg_mode == MODE_SW || cfg_mode == MODE_XI) begin
         left_x_hold = snap_stick(q.stick_x, 1'b0);
         left_y_hold = snap_stick(q.stick_y, cfg_mode == MODE_XI);
      end
      o.left_x = left_x_hold;
      o.left_y = left_y_hold;
      o.gyro_active = aim_on;
      return o;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (!reset && (req_fire || !req_valid)) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) req_gap <= $urandom_range(1, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet && $urandom_range(0, 9) == 0) rsp_gap <= $urandom_range(1, 13);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      req_fire <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) expected_rsps.push_back(predict_rsp(req_data));
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            fail_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.right_x !== want.right_x) begin
               $error("right_x expected %0d actual %0d", want.right_x, rsp_data.right_x);
               fail_count++;
            end
            if (rsp_data.right_y !== want.right_y) begin
               $error("right_y expected %0d actual %0d", want.right_y, rsp_data.right_y);
               fail_count++;
            end
            if (rsp_data.left_x !== want.left_x) begin
               $error("left_x expected %0d actual %0d", want.left_x, rsp_data.left_x);
               fail_count++;
            end
            if (rsp_data.left_y !== want.left_y) begin
               $error("left_y expected %0d actual %0d", want.left_y, rsp_data.left_y);
               fail_count++;
            end
            if (rsp_data.gyro_active !== want.gyro_active) begin
               $error("gyro_active expected %0d actual %0d", want.gyro_active,
                      rsp_data.gyro_active);
               fail_count++;
            end
         end
      end
   end

   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MODE:      cfg_mode = val[1:0];
         CSR_YAW_DZ:    cfg_yaw_dz = val[7:0];
         CSR_ROLL_DZ:   cfg_roll_dz = val[7:0];
         CSR_YAW_GAIN:  cfg_yaw_gain = val[7:0];
         CSR_ROLL_GAIN: cfg_roll_gain = val[7:0];
         CSR_CENTRE:    cfg_centre = val;
         CSR_STICK_DZ:  cfg_stick_dz = val[10:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_all(logic [1:0] m, logic [11:0] ydz, logic [11:0] rdz, logic [11:0] yg,
                          logic [11:0] rg, logic [11:0] c, logic [11:0] sdz);
      write_reg(CSR_MODE, {10'd0, m});
      write_reg(CSR_YAW_DZ, ydz);
      write_reg(CSR_ROLL_DZ, rdz);
      write_reg(CSR_YAW_GAIN, yg);
      write_reg(CSR_ROLL_GAIN, rg);
      write_reg(CSR_CENTRE, c);
      write_reg(CSR_STICK_DZ, sdz);
   endtask

   task automatic push_req(bit qv, logic [31:0] x, logic [31:0] y, logic [31:0] z, bit p,
                           logic [11:0] sx, logic [11:0] sy);
      req_type r;
      r.quat_valid = qv;
      r.quat_x = x;
      r.quat_y = y;
      r.quat_z = z;
      r.gyro_pressed = p;
      r.stick_x = sx;
      r.stick_y = sy;
      pending_reqs.push_back(r);
   endtask

   function automatic logic [31:0] small_comp();
      return 32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000);
   endfunction

   function automatic logic [11:0] stick_sample();
      if ($urandom_range(0, 2) == 0) return 12'($urandom_range(1600, 2500));
      return 12'($urandom_range(0, 4095));
   endfunction

   task automatic push_random(int n);
      bit p;
      p = $urandom_range(0, 1);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0) p = !p;
         if ($urandom_range(0, 6) == 0)
            push_req($urandom_range(0, 1), $urandom, $urandom, $urandom, p,
                     stick_sample(), stick_sample());
         else
            push_req($urandom_range(0, 4) != 0, small_comp(), small_comp(), small_comp(), p,
                     stick_sample(), stick_sample());
      end
   endtask

   task automatic wait_idle();
      wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (20) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_mode = MODE_XI;
      cfg_yaw_dz = 8'd2;
      cfg_roll_dz = 8'd3;
      cfg_yaw_gain = 8'd24;
      cfg_roll_gain = 8'd27;
      cfg_centre = 12'd1975;
      cfg_stick_dz = 11'd260;
      q_w = Q30; q_x = 0; q_y = 0; q_z = 0;
      aim_on = 0; ref_yaw = 0; ref_roll = 0;
      left_x_hold = '0; left_y_hold = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed requests at reset settings
      push_req(0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 12'd0, 12'd4095);
      push_req(0, 0, 0, 0, 1, 12'd2048, 12'd2048);
      push_req(1, 32'h2000_0000, 32'h2000_0000, 0, 1, 12'd1789, 12'd2307);
      push_req(1, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 1, 12'd1788, 12'd2308);
      push_req(1, 32'hE000_0000, 32'h1000_0000, 32'hF000_0000, 1, 12'd4095, 12'd0);
      push_req(1, 32'h4000_0000, 0, 0, 1, 12'd1, 12'd4094);
      push_req(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 12'd2047, 12'd2049);
      push_req(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 12'd100, 12'd3000);
      push_req(1, 0, 0, 32'h3000_0000, 1, 12'd2200, 12'd1900);
      push_req(1, 0, 0, 32'hD000_0000, 1, 12'd2200, 12'd1900);
      push_req(1, 0, 32'h3FFF_FFFF, 0, 1, 12'd500, 12'd500);
      push_req(1, 32'hC000_0001, 0, 0, 1, 12'd500, 12'd500);
      push_req(1, 0, 0, 0, 0, 12'd3500, 12'd3500);
      push_req(1, 32'h1800_0000, 32'hE800_0000, 32'h0800_0000, 1, 12'd2048, 12'd0);
      push_req(0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 1, 12'd4095, 12'd4095);
      push_req(1, 32'hF000_0000, 32'h2800_0000, 32'hE000_0000, 1, 12'd10, 12'd4000);
      push_req(1, 0, 0, 0, 0, 12'd2048, 12'd2048);
      wait_idle();

      set_all(MODE_DI, 12'd0, 12'd0, 12'd255, 12'd255, 12'd0, 12'd0);
      push_req(0, 0, 0, 0, 0, 12'd2048, 12'd2048);
      push_random(40);
      wait_idle();
      set_all(MODE_SW, 12'hFFF, 12'd180, 12'd0, 12'd0, 12'd4095, 12'd2047);
      write_reg(BAD_INDEX, 12'hFFF);
      push_random(40);
      wait_idle();
      set_all(MODE_RETRO, 12'd180, 12'd0, 12'd255, 12'd1, 12'd4000, 12'd2047);
      push_random(40);
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         set_all($urandom_range(0, 3), $urandom_range(0, 12), $urandom_range(0, 12),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 4095),
                 $urandom_range(0, 600));
         if (ph == 7) quiet = 1;
         push_random(55);
         wait_idle();
      end

      repeat (200) @(negedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
